[rtl/core/lsfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_pkg: shared types and constants of the LED strip frame serializer
// Command format between front and back, byte step codes, frame constants.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  localparam logic [7:0]  MAGIC0     = 8'h41;
  localparam logic [7:0]  MAGIC1     = 8'h64;
  localparam logic [7:0]  MAGIC2     = 8'h61;
  localparam logic [7:0]  HDR_XOR    = 8'h55;
  localparam logic [31:0] HASH_GOLD  = 32'h9e37_79b9;

  // command queue
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = 1;
  localparam int unsigned CMD_CNT_W = 2;

  // byte steps of one command
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MAGIC0 = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MAGIC1 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAGIC2 = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CNT_HI = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CNT_LO = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HDR_CK = 4'd5;
  localparam logic [STEP_W-1:0] STEP_GREEN  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RED    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_BLUE   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CSUM0  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CSUM1  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_CSUM2  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_CSUM3  = 4'd12;

  typedef struct packed {
    logic        hdr;     // first LED of a frame: send header
    logic [7:0]  cnt_hi;
    logic [7:0]  cnt_lo;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
    logic        last;    // last LED: send checksum
    logic [31:0] csum;    // checksum after folding this LED
  } cmd_t;

endpackage
`default_nettype wire

[rtl/core/lsfs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_front: item intake
// Tracks frame position, folds the hash step and builds one command per LED.
// ----------------------------------------------------------------------------
module lsfs_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     red,
  input  wire logic [7:0]     green,
  input  wire logic [7:0]     blue,
  input  wire logic [16:0]    led_count,
  input  wire logic           last_led,
  output logic                cmd_push,
  input  wire logic           cmd_full,
  output lsfs_pkg::cmd_t      cmd
);

  logic        in_frame_r, in_frame_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic        accept;
  logic [31:0] h;
  logic [31:0] folded;
  logic [15:0] adj;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;

  assign h      = {red, green, 8'h00, blue};
  assign folded = (csum_r + lsfs_pkg::HASH_GOLD + {h[25:0], 6'b0} + {2'b0, h[31:2]}) ^ h;
  assign adj    = led_count[15:0] - 16'd1;

  always_comb begin
    cmd.hdr    = !in_frame_r;
    cmd.cnt_hi = adj[15:8];
    cmd.cnt_lo = adj[7:0];
    cmd.green  = green;
    cmd.red    = red;
    cmd.blue   = blue;
    cmd.last   = last_led;
    cmd.csum   = folded;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    csum_nxt     = csum_r;
    if (accept) begin
      // drop back to awaiting a frame on the last LED
      in_frame_nxt = !last_led;
      csum_nxt     = last_led ? 32'd0 : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      csum_r     <= 32'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      csum_r     <= csum_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_led |=> !in_frame_r && csum_r == 32'd0)
    else $error("frame state not cleared after last LED");
`endif

endmodule
`default_nettype wire

[rtl/core/lsfs_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_cmd_fifo: command queue
// Short first-in first-out queue decoupling intake from byte generation.
// ----------------------------------------------------------------------------
module lsfs_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire lsfs_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output lsfs_pkg::cmd_t      rd_data,
  output logic                empty
);

  lsfs_pkg::cmd_t                    mem_r [lsfs_pkg::CMD_DEPTH];
  logic [lsfs_pkg::CMD_PTR_W-1:0]    wptr_r, rptr_r;
  logic [lsfs_pkg::CMD_CNT_W-1:0]    count_r, count_nxt;
  logic                              do_wr, do_rd;

  assign full    = (count_r == lsfs_pkg::CMD_CNT_W'(lsfs_pkg::CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lsfs_pkg::CMD_CNT_W'(lsfs_pkg::CMD_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule
`default_nettype wire

[rtl/core/lsfs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_back: byte sequencer
// Walks the byte steps of the head command into a one-entry output register.
// ----------------------------------------------------------------------------
module lsfs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lsfs_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_frame_end
);

  logic                        active_r, active_nxt;
  logic [lsfs_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [lsfs_pkg::STEP_W-1:0] cur_step, end_step;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        run_last_r, run_last_nxt;
  logic                        frame_end_r, frame_end_nxt;
  logic                        advance;
  logic                        at_end;
  logic [7:0]                  sel_byte;

  assign empty         = !out_valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

  assign advance  = !cmd_empty && (!out_valid_r || pop);
  assign cur_step = active_r ? step_r
                  : (cmd.hdr ? lsfs_pkg::STEP_MAGIC0 : lsfs_pkg::STEP_GREEN);
  assign end_step = cmd.last ? lsfs_pkg::STEP_CSUM3 : lsfs_pkg::STEP_BLUE;
  assign at_end   = (cur_step == end_step);
  assign cmd_pop  = advance && at_end;

  always_comb begin
    case (cur_step)
      lsfs_pkg::STEP_MAGIC0: sel_byte = lsfs_pkg::MAGIC0;
      lsfs_pkg::STEP_MAGIC1: sel_byte = lsfs_pkg::MAGIC1;
      lsfs_pkg::STEP_MAGIC2: sel_byte = lsfs_pkg::MAGIC2;
      lsfs_pkg::STEP_CNT_HI: sel_byte = cmd.cnt_hi;
      lsfs_pkg::STEP_CNT_LO: sel_byte = cmd.cnt_lo;
      lsfs_pkg::STEP_HDR_CK: sel_byte = cmd.cnt_hi ^ cmd.cnt_lo ^ lsfs_pkg::HDR_XOR;
      lsfs_pkg::STEP_GREEN:  sel_byte = cmd.green;
      lsfs_pkg::STEP_RED:    sel_byte = cmd.red;
      lsfs_pkg::STEP_BLUE:   sel_byte = cmd.blue;
      lsfs_pkg::STEP_CSUM0:  sel_byte = cmd.csum[7:0];
      lsfs_pkg::STEP_CSUM1:  sel_byte = cmd.csum[15:8];
      lsfs_pkg::STEP_CSUM2:  sel_byte = cmd.csum[23:16];
      lsfs_pkg::STEP_CSUM3:  sel_byte = cmd.csum[31:24];
      default:               sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !pop;
    byte_nxt      = byte_r;
    run_last_nxt  = run_last_r;
    frame_end_nxt = frame_end_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = sel_byte;
      run_last_nxt  = at_end;
      frame_end_nxt = (cur_step == lsfs_pkg::STEP_CSUM3);
      active_nxt    = !at_end;
      step_nxt      = cur_step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    byte_r      <= byte_nxt;
    run_last_r  <= run_last_nxt;
    frame_end_r <= frame_end_nxt;
  end

`ifndef ASSERT_OFF
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_end_r |-> run_last_r)
    else $error("frame end byte not marked as last of its request");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> out_valid_r && run_last_r)
    else $error("command retired without its last byte");
`endif

endmodule
`default_nettype wire

[rtl/core/led_strip_frame_serializer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_frame_serializer_top: LED colors to serial LED frame bytes
// Header on a frame's first LED, G/R/B per LED, 32-bit hash checksum at end.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  input    push / full          in_red, in_green, in_blue, in_led_count,
//                                in_last_led (one request per LED)
//  result   empty / pop          out_byte, out_run_last, out_frame_end
//                                (one request per byte)
//
//  One byte leaves the output register per cycle while pop is held; an LED
//  request yields 3 bytes, 9 with a header, 7 with a checksum, 13 for a
//  single-LED frame, so a steady stream is paced by the byte sequencer.
//  Intake takes one request per cycle until the 2-entry command queue fills.
//  Synchronous reset clears frame state, checksum and queue, and empties the output register.
//  A stalled pop holds the output byte; intake keeps going into the queue until it fills.
//
module led_strip_frame_serializer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [16:0] in_led_count,
  input  wire logic        in_last_led,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_frame_end
);

  lsfs_pkg::cmd_t wr_cmd;
  lsfs_pkg::cmd_t head_cmd;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;

  // Classify each LED, fold the checksum, and queue a command.
  lsfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .led_count (in_led_count),
    .last_led  (in_last_led),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full),
    .cmd       (wr_cmd)
  );

  // Hold commands so intake and byte output stall independently.
  lsfs_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (wr_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (head_cmd),
    .empty   (cmd_empty)
  );

  // Step through the head command's bytes into the output register.
  lsfs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (head_cmd),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire
